/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Assertion helpers shared by the rational arithmetic unit modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define RAU_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, payload structs, command and state codes for the controller and
// the datapath, and the operand normalization used by the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int FIELD_W       = 16;
    localparam int CMD_W         = 3;
    localparam int NUM_W         = 33;
    localparam int DEN_W         = 31;

    // magnitude width of products and sums
    localparam int MW    = 2 * OPERAND_WIDTH;
    // signed width of a cross-product sum
    localparam int SW    = MW + 2;
    localparam int EXT_W = (OPERAND_WIDTH > FIELD_W) ? OPERAND_WIDTH : FIELD_W;
    localparam int WW    = (MW + 1 > NUM_W) ? MW + 1 : NUM_W;
    localparam int K_W   = $clog2(MW + 1);
    localparam int CNT_W = $clog2(MW);

    typedef enum logic [CMD_W-1:0] {
        CMD_NORM = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    less;
        logic                    equal;
        logic                    greater;
        logic                    div_by_zero;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_MUL_D,
        ST_MUL_N,
        ST_SUM,
        ST_MAG,
        ST_GCD,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MSEL_NONE,
        MSEL_L,
        MSEL_R,
        MSEL_D,
        MSEL_N
    } t_msel;

    typedef struct packed {
        logic  load;
        t_msel msel;
        logic  sum;
        logic  mag;
        logic  gcd_step;
        logic  scale;
        logic  div_step;
        logic  show;
    } t_ctl;

    typedef struct packed {
        logic gcd_eq;
    } t_sts;

    typedef struct packed {
        logic                     n_neg;
        logic [OPERAND_WIDTH-1:0] n_mag;
        logic [OPERAND_WIDTH-1:0] d_mag;
    } t_opnd;

    // Sign-extend the low operand bits, force a zero denominator to one and
    // move the sign into the numerator.
    function automatic t_opnd norm_opnd(input logic [FIELD_W-1:0] num,
                                        input logic [FIELD_W-1:0] den);
        logic [EXT_W-1:0]         nx;
        logic [EXT_W-1:0]         dx;
        logic [OPERAND_WIDTH-1:0] n;
        logic [OPERAND_WIDTH-1:0] d;
        logic [OPERAND_WIDTH-1:0] nm;
        t_opnd                    r;
        nx = EXT_W'(num);
        dx = EXT_W'(den);
        n  = nx[OPERAND_WIDTH-1:0];
        d  = dx[OPERAND_WIDTH-1:0];
        nm = n[OPERAND_WIDTH-1] ? OPERAND_WIDTH'(~n + 1'b1) : n;
        r.n_mag = nm;
        r.n_neg = (n[OPERAND_WIDTH-1] ^ d[OPERAND_WIDTH-1]) && (nm != '0);
        if (d == '0) begin
            r.d_mag = OPERAND_WIDTH'(1);
        end else if (d[OPERAND_WIDTH-1]) begin
            r.d_mag = OPERAND_WIDTH'(~d + 1'b1);
        end else begin
            r.d_mag = d;
        end
        return r;
    endfunction

endpackage

/* sv/rau_ctrl.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences the shared multiplier, sum, GCD and divide steps of the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_ctrl
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_busy,
    output logic o_valid
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MW - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             idle_like;

    assign idle_like = (r_state == ST_IDLE) || (r_state == ST_DONE);
    assign o_busy    = !idle_like;
    assign o_valid   = (r_state == ST_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_MUL_L;
            ST_MUL_L: n_state = ST_MUL_R;
            ST_MUL_R: n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_MUL_N;
            ST_MUL_N: n_state = ST_SUM;
            ST_SUM:   n_state = ST_MAG;
            ST_MAG:   n_state = ST_GCD;
            ST_GCD:   if (i_sts.gcd_eq) n_state = ST_SCALE;
            ST_SCALE: begin
                n_state = ST_DIV;
                n_cnt   = '0;
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_MAX) n_state = ST_DONE;
            end
            ST_DONE:  n_state = i_start ? ST_MUL_L : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_ctl.msel = MSEL_NONE;
        o_ctl.load = i_start && idle_like;
        unique case (r_state)
            ST_MUL_L: o_ctl.msel     = MSEL_L;
            ST_MUL_R: o_ctl.msel     = MSEL_R;
            ST_MUL_D: o_ctl.msel     = MSEL_D;
            ST_MUL_N: o_ctl.msel     = MSEL_N;
            ST_SUM:   o_ctl.sum      = 1'b1;
            ST_MAG:   o_ctl.mag      = 1'b1;
            ST_GCD:   o_ctl.gcd_step = 1'b1;
            ST_SCALE: o_ctl.scale    = 1'b1;
            ST_DIV:   o_ctl.div_step = 1'b1;
            ST_DONE:  o_ctl.show     = 1'b1;
            default:  o_ctl.msel     = MSEL_NONE;
        endcase
    end

    `RAU_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "result strobe held two cycles")
    `RAU_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "transfer did not start work")
    `RAU_ASSERT_IMP(a_valid_after_div, o_valid, $past(r_state) == ST_DIV, "strobe without divide")

endmodule

/* sv/rau_dp.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand normalization, one shared multiplier, cross-product sum, binary GCD
// and two bit-serial exact dividers that reduce the fraction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_dp
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  t_ctl i_ctl,
    output t_sts o_sts,
    output t_out o_res
);

    t_opnd                    r_a, r_b;
    logic [CMD_W-1:0]         r_cmd;
    logic [MW-1:0]            r_pl, r_pr, r_pd, r_pn;
    logic [SW-1:0]            r_acc;
    logic                     r_neg, r_less, r_equal, r_greater, r_dz;
    logic [MW-1:0]            r_m, r_den, r_u, r_v, r_rm, r_rd;
    logic [K_W-1:0]           r_k;

    logic [OPERAND_WIDTH-1:0] mul_a, mul_b;
    logic [MW-1:0]            prod;
    logic [SW-1:0]            lhs, rhs, n_acc, acc_mag;
    logic [MW-1:0]            n_den;
    logic                     n_dz, prod_neg;
    logic [MW:0]              rm_sh, rd_sh;
    logic                     rm_ge, rd_ge;
    logic [WW-1:0]            q_num, q_sgn, q_den;

    function automatic logic [SW-1:0] signed_val(input logic neg, input logic [MW-1:0] m);
        logic [SW-1:0] x;
        x = SW'(m);
        return neg ? (~x + 1'b1) : x;
    endfunction

    // shared multiplier
    always_comb begin
        mul_a = r_a.n_mag;
        mul_b = r_b.d_mag;
        unique case (i_ctl.msel)
            MSEL_L: begin
                mul_a = r_a.n_mag;
                mul_b = r_b.d_mag;
            end
            MSEL_R: begin
                mul_a = r_b.n_mag;
                mul_b = r_a.d_mag;
            end
            MSEL_D: begin
                mul_a = r_a.d_mag;
                mul_b = r_b.d_mag;
            end
            MSEL_N: begin
                mul_a = r_a.n_mag;
                mul_b = r_b.n_mag;
            end
            default: begin
                mul_a = r_a.n_mag;
                mul_b = r_b.d_mag;
            end
        endcase
    end

    assign prod     = MW'(mul_a) * MW'(mul_b);
    assign lhs      = signed_val(r_a.n_neg, r_pl);
    assign rhs      = signed_val(r_b.n_neg, r_pr);
    assign prod_neg = r_a.n_neg ^ r_b.n_neg;

    always_comb begin
        n_acc = '0;
        n_den = MW'(1);
        n_dz  = 1'b0;
        unique case (r_cmd)
            CMD_NORM: begin
                n_acc = signed_val(r_a.n_neg, MW'(r_a.n_mag));
                n_den = MW'(r_a.d_mag);
            end
            CMD_ADD: begin
                n_acc = lhs + rhs;
                n_den = r_pd;
            end
            CMD_SUB: begin
                n_acc = lhs - rhs;
                n_den = r_pd;
            end
            CMD_MUL: begin
                n_acc = signed_val(prod_neg, r_pn);
                n_den = r_pd;
            end
            CMD_DIV: begin
                if (r_b.n_mag == '0) begin
                    n_dz = 1'b1;
                end else begin
                    n_acc = signed_val(prod_neg, r_pl);
                    n_den = r_pr;
                end
            end
            default: begin
                n_acc = '0;
                n_den = MW'(1);
            end
        endcase
    end

    assign acc_mag = r_acc[SW-1] ? (~r_acc + 1'b1) : r_acc;

    assign o_sts.gcd_eq = (r_u == r_v);

    assign rm_sh = {r_rm, r_m[MW-1]};
    assign rd_sh = {r_rd, r_den[MW-1]};
    assign rm_ge = rm_sh >= {1'b0, r_u};
    assign rd_ge = rd_sh >= {1'b0, r_u};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a   <= norm_opnd(i_item.a_num, i_item.a_den);
            r_b   <= norm_opnd(i_item.b_num, i_item.b_den);
            r_cmd <= i_item.command;
        end
        unique case (i_ctl.msel)
            MSEL_L:  r_pl <= prod;
            MSEL_R:  r_pr <= prod;
            MSEL_D:  r_pd <= prod;
            MSEL_N:  r_pn <= prod;
            default: r_pl <= r_pl;
        endcase
        if (i_ctl.sum) begin
            r_acc     <= n_acc;
            r_den     <= n_den;
            r_dz      <= n_dz;
            r_less    <= $signed(lhs) < $signed(rhs);
            r_equal   <= lhs == rhs;
            r_greater <= $signed(lhs) > $signed(rhs);
        end
        if (i_ctl.mag) begin
            r_k <= '0;
            r_m <= acc_mag[MW-1:0];
            if (acc_mag == '0) begin
                // zero result reduces to 0/1
                r_neg <= 1'b0;
                r_den <= MW'(1);
                r_u   <= MW'(1);
                r_v   <= MW'(1);
            end else begin
                r_neg <= r_acc[SW-1];
                r_u   <= acc_mag[MW-1:0];
                r_v   <= r_den;
            end
        end
        if (i_ctl.gcd_step && (r_u != r_v)) begin
            priority if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
        if (i_ctl.scale) begin
            // restore the common power of two
            r_u  <= r_u << r_k;
            r_rm <= '0;
            r_rd <= '0;
        end
        if (i_ctl.div_step) begin
            r_rm  <= rm_ge ? MW'(rm_sh - {1'b0, r_u}) : rm_sh[MW-1:0];
            r_rd  <= rd_ge ? MW'(rd_sh - {1'b0, r_u}) : rd_sh[MW-1:0];
            r_m   <= {r_m[MW-2:0], rm_ge};
            r_den <= {r_den[MW-2:0], rd_ge};
        end
    end

    assign q_num = WW'(r_m);
    assign q_sgn = r_neg ? (~q_num + 1'b1) : q_num;
    assign q_den = WW'(r_den);

    assign o_res.res_num     = q_sgn[NUM_W-1:0];
    assign o_res.res_den     = q_den[DEN_W-1:0];
    assign o_res.less        = r_less;
    assign o_res.equal       = r_equal;
    assign o_res.greater     = r_greater;
    assign o_res.div_by_zero = r_dz;

    `RAU_ASSERT_IMP(a_gcd_nonzero, i_ctl.gcd_step, (r_u != '0) && (r_v != '0), "GCD operand zero")
    `RAU_ASSERT_NEXT(a_rem_bound, i_ctl.div_step, (r_rm < r_u) && (r_rd < r_u), "remainder overflow")
    `RAU_ASSERT_IMP(a_den_nonzero, i_ctl.show, r_den != '0, "reduced denominator zero")
    `RAU_ASSERT_IMP(a_zero_unsigned, i_ctl.show && (r_m == '0), !r_neg, "negative zero result")

endmodule

/* sv/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Normalizes two signed fractions and returns a reduced sum, difference,
// product, quotient or normalized a, with a-versus-b comparison flags.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. After the transfer the
// unit runs ST_MUL_L, ST_MUL_R, ST_MUL_D and ST_MUL_N on one shared 16x16
// multiplier, then the sum, magnitude, binary-GCD and scale steps and the
// restoring divide (one quotient bit per cycle for numerator and denominator
// together); o_valid then pulses for one cycle with the result on o_res. The
// number of GCD steps depends on the data and is at most 122: the two
// reduction operands hold at most 63 bits between them and keep at least one
// each, each halving step drops at least one of those bits and each
// subtraction is followed by a halving. A new item may start in the cycle that
// shows the result. o_valid cannot be held off: capture o_res in that cycle.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_res
);

    t_ctl ctl;
    t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    rau_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_res   (o_res)
    );

endmodule

/* sim/rau_checker.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches the command and result channels of the unit. For every command
// transfer it computes the reduced fraction and the comparison flags on its
// own. Each result strobe is compared field by field with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module rau_checker
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  t_in  i_item,
    input  logic o_valid,
    input  t_out o_res,
    input  logic i_drained,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);

    typedef struct {
        t_in  src;
        t_out want;
    } t_fraction_exp;

    t_fraction_exp expected_fractions[$];
    int            errors       = 0;
    int            checked      = 0;
    logic          drained_seen = 1'b0;

    // Low operand bits, sign-extended.
    function automatic longint operand_value(input logic [FIELD_W-1:0] v);
        logic [63:0] u;
        u = 64'(v) & ((64'd1 << OPERAND_WIDTH) - 64'd1);
        if (u[OPERAND_WIDTH-1]) begin
            u = u - (64'd1 << OPERAND_WIDTH);
        end
        return longint'(u);
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic t_out fraction_result(input t_in it);
        longint      an;
        longint      ad;
        longint      bn;
        longint      bd;
        longint      lhs;
        longint      rhs;
        longint      sum;
        logic [63:0] m;
        logic [63:0] den;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic        neg;
        t_out        r;
        an = operand_value(it.a_num);
        ad = operand_value(it.a_den);
        bn = operand_value(it.b_num);
        bd = operand_value(it.b_den);
        // zero denominator counts as one; the sign moves to the numerator
        if (ad == 0) ad = 1;
        if (ad < 0) begin
            ad = -ad;
            an = -an;
        end
        if (bd == 0) bd = 1;
        if (bd < 0) begin
            bd = -bd;
            bn = -bn;
        end
        lhs = an * bd;
        rhs = bn * ad;
        neg = 1'b0;
        m   = '0;
        den = 64'd1;
        r   = '0;
        case (t_cmd'(it.command))
            CMD_NORM: begin
                neg = an < 0;
                m   = magnitude(an);
                den = 64'(ad);
            end
            CMD_ADD, CMD_SUB: begin
                sum = (t_cmd'(it.command) == CMD_ADD) ? lhs + rhs : lhs - rhs;
                neg = sum < 0;
                m   = magnitude(sum);
                den = 64'(ad * bd);
            end
            CMD_MUL: begin
                neg = (an < 0) != (bn < 0);
                m   = magnitude(an) * magnitude(bn);
                den = 64'(ad * bd);
            end
            CMD_DIV: begin
                if (bn == 0) begin
                    r.div_by_zero = 1'b1;
                end else begin
                    neg = (an < 0) != (bn < 0);
                    m   = magnitude(an) * 64'(bd);
                    den = 64'(ad) * magnitude(bn);
                end
            end
            default: begin
            end
        endcase
        // reduce by the greatest common divisor
        x = m;
        y = den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        m   = m / x;
        den = den / x;
        if (m == 0) begin
            neg = 1'b0;
            den = 64'd1;
        end
        r.res_num = neg ? NUM_W'(-m) : NUM_W'(m);
        r.res_den = DEN_W'(den);
        r.less    = lhs < rhs;
        r.equal   = lhs == rhs;
        r.greater = lhs > rhs;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_in src,
                                   input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d (cmd %0d a %0d/%0d b %0d/%0d)",
                 what, got, want, src.command, src.a_num, src.a_den,
                 src.b_num, src.b_den);
    endtask

    task automatic compare_result(input t_fraction_exp e, input t_out got);
        if (got.res_num !== e.want.res_num)
            report_mismatch("res_num", e.src, got.res_num, e.want.res_num);
        if (got.res_den !== e.want.res_den)
            report_mismatch("res_den", e.src, got.res_den, e.want.res_den);
        if (got.less !== e.want.less)
            report_mismatch("less", e.src, got.less, e.want.less);
        if (got.equal !== e.want.equal)
            report_mismatch("equal", e.src, got.equal, e.want.equal);
        if (got.greater !== e.want.greater)
            report_mismatch("greater", e.src, got.greater, e.want.greater);
        if (got.div_by_zero !== e.want.div_by_zero)
            report_mismatch("div_by_zero", e.src, got.div_by_zero, e.want.div_by_zero);
    endtask

    always @(posedge i_clk) begin : watch
        t_fraction_exp head;
        if (i_rst_n) begin
            // check the result first: an item taken at this edge is not answered yet
            if (o_valid) begin
                if (expected_fractions.size() == 0) begin
                    report_mismatch("result with none outstanding", '0,
                                    o_res.res_num, 0);
                end else begin
                    head = expected_fractions.pop_front();
                    compare_result(head, o_res);
                    checked++;
                end
            end
            if (start && !busy) begin
                head.src  = i_item;
                head.want = fraction_result(i_item);
                expected_fractions.push_back(head);
            end
            if (i_drained && !drained_seen) begin
                drained_seen = 1'b1;
                foreach (expected_fractions[k])
                    report_mismatch("result never came", expected_fractions[k].src,
                                    0, expected_fractions[k].want.res_num);
                expected_fractions.delete();
            end
        end
        o_errors  <= errors;
        o_pending <= expected_fractions.size();
        o_checked <= checked;
    end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends a directed set of fraction commands (extremes, zero denominators,
// zero results, divide by zero, spare command codes) and then random ones,
// with random idle cycles on the command side. The checker beside the unit
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import rau_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_valid;
    t_out o_res;
    logic drained;
    int   errors;
    int   pending;
    int   checked;
    logic idling_on;
    int   sent = 0;
    int   directed = 0;

    always #6 i_clk = ~i_clk;

    rational_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    rau_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .o_res     (o_res),
        .i_drained (drained),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    // While idling_on is set, hold start low on random cycles until the transfer happens.
    task automatic transfer_item(input t_in item);
        logic hold;
        i_item <= item;
        do begin
            hold = idling_on && ($urandom_range(99) < 20);
            start <= !hold;
            @(posedge i_clk);
        end while (!(start && !busy));
        sent++;
    endtask

    task automatic issue_fraction_op(input logic [CMD_W-1:0] cmd, input int an,
                                     input int ad, input int bn, input int bd);
        t_in item;
        item.command = cmd;
        item.a_num   = FIELD_W'(an);
        item.a_den   = FIELD_W'(ad);
        item.b_num   = FIELD_W'(bn);
        item.b_den   = FIELD_W'(bd);
        transfer_item(item);
    endtask

    function automatic logic [FIELD_W-1:0] random_field();
        case ($urandom_range(9))
            4, 5:    return FIELD_W'(int'($urandom_range(40)) - 20);
            6: begin
                case ($urandom_range(4))
                    0:       return FIELD_W'(-32768);
                    1:       return FIELD_W'(-1);
                    2:       return FIELD_W'(1);
                    3:       return FIELD_W'(32767);
                    default: return '0;
                endcase
            end
            7:       return '0;
            8, 9:    return FIELD_W'(int'($urandom_range(2000)) - 1000);
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // Every field gets its own bin, so every bit of every field toggles.
    function automatic t_in random_item();
        t_in item;
        if ($urandom_range(99) < 10)
            item.command = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        else
            item.command = CMD_W'($urandom_range(CMD_DIV, CMD_NORM));
        item.a_num = random_field();
        item.a_den = random_field();
        item.b_num = random_field();
        item.b_den = random_field();
        return item;
    endfunction

    initial begin
        int waited;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_item    <= '0;
        drained   <= 1'b0;
        idling_on = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_fraction_op(CMD_NORM, 6, -4, 0, 0);
        issue_fraction_op(CMD_NORM, 5, 0, 1, 1);
        issue_fraction_op(CMD_NORM, -32768, -32768, 3, 2);
        issue_fraction_op(CMD_NORM, 0, -5, 0, -5);
        issue_fraction_op(CMD_ADD, 1, 2, 1, 3);
        issue_fraction_op(CMD_ADD, 1, 3, 1, 2);
        issue_fraction_op(CMD_ADD, -32768, 32767, -32768, 32767);
        issue_fraction_op(CMD_ADD, 32767, -32768, 32767, -32768);
        issue_fraction_op(CMD_SUB, 1, 2, 1, 3);
        issue_fraction_op(CMD_SUB, 3, 7, -6, -14);
        issue_fraction_op(CMD_SUB, 32767, 1, -32768, 1);
        issue_fraction_op(CMD_MUL, -2, 3, 3, -4);
        issue_fraction_op(CMD_MUL, -32768, 1, -32768, 1);
        issue_fraction_op(CMD_MUL, 0, 0, 0, 0);
        issue_fraction_op(CMD_DIV, 1, 2, -1, 4);
        issue_fraction_op(CMD_DIV, -7, -3, 14, 6);
        issue_fraction_op(CMD_DIV, 5, 3, 0, 7);
        issue_fraction_op(CMD_DIV, 5, 3, 0, 0);
        issue_fraction_op(CMD_DIV, -32768, 1, 1, -32768);
        issue_fraction_op(CMD_DIV, 32767, -32768, -32768, 32767);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            issue_fraction_op(CMD_W'(c), 2, 5, -3, 4);
        directed = sent;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // a long stretch with start held high back to back
            idling_on = !(n >= 700 && n < 1200);
            transfer_item(random_item());
        end
        start <= 1'b0;

        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        drained <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Sent %0d commands (%0d directed, all eight command codes)", sent, directed);
        $display("Checked %0d results against predicted reduced fractions", checked);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #16_000_000;
        $display("Timeout: run did not finish");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/rau_pkg.sv
sv/rau_ctrl.sv
sv/rau_dp.sv
sv/rational_arithmetic_unit.sv
sim/rau_checker.sv
sim/tb_top.sv
